// ===== hw/rtl/gfsbox_pkg.sv =====
// gfsbox_pkg: shared types, constants and helper functions for the gf(2^8) substitution block
// used by gfsbox_euclid_step and gf256_sbox_forward_inverse; no dependencies
`default_nettype none

package gfsbox_pkg;

    localparam logic [7:0] FWD_ROW   = 8'hF1;
    localparam logic [7:0] INV_ROW   = 8'hA4;
    localparam logic [7:0] FWD_CONST = 8'h63;
    localparam logic [7:0] INV_CONST = 8'h05;
    localparam logic [7:0] POLY_RST  = 8'h1B;

    localparam logic       KIND_FWD  = 1'b0;
    localparam logic       KIND_INV  = 1'b1;

    typedef struct packed {
        logic [8:0] u;
        logic [8:0] v;
        logic [7:0] g0;
        logic [7:0] g1;
    } t_euclid;

    // position of the highest set bit, zero for zero
    function automatic logic [3:0] degree9(input logic [8:0] p);
        logic [3:0] d;
        d = 4'd0;
        for (int i = 0; i < 9; i++) begin
            if (p[i]) begin
                d = 4'(i);
            end
        end
        return d;
    endfunction

    // bit k is the parity of (rotl(row, k) & x) xor bit k of c
    function automatic logic [7:0] affine8(input logic [7:0] x, input logic [7:0] row,
                                           input logic [7:0] c);
        logic [7:0]  res;
        logic [15:0] rr;
        res = 8'd0;
        for (int k = 0; k < 8; k++) begin
            rr     = {row, row} << k;
            res[k] = (^(rr[15:8] & x)) ^ c[k];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gfsbox_euclid_step.sv =====
// gfsbox_euclid_step: one step of the binary extended euclid over gf(2) polynomials
// depends on gfsbox_pkg for t_euclid and degree9
`default_nettype none

module gfsbox_euclid_step
    import gfsbox_pkg::*;
(
    input  t_euclid i_cur,
    output t_euclid o_nxt
);

    logic [3:0] du;
    logic [3:0] dv;
    logic       swap;
    logic [3:0] sh;
    logic [8:0] uu;
    logic [8:0] vv;
    logic [7:0] a0;
    logic [7:0] a1;
    logic [8:0] vsh;
    logic [7:0] gsh;

    always_comb begin
        du   = degree9(i_cur.u);
        dv   = degree9(i_cur.v);
        swap = (du < dv);
        sh   = swap ? (dv - du) : (du - dv);
        uu   = swap ? i_cur.v  : i_cur.u;
        vv   = swap ? i_cur.u  : i_cur.v;
        a0   = swap ? i_cur.g1 : i_cur.g0;
        a1   = swap ? i_cur.g0 : i_cur.g1;
        vsh  = vv << sh;
        gsh  = a1 << sh;
        o_nxt.u  = uu ^ vsh;
        o_nxt.v  = vv;
        o_nxt.g0 = a0 ^ gsh;
        o_nxt.g1 = a1;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gf256_sbox_forward_inverse.sv =====
// gf256_sbox_forward_inverse: forward and inverse byte substitution over gf(2^8)
// depends on gfsbox_pkg and gfsbox_euclid_step
//
// usage
//   input stream: tdata carries the byte, tuser the direction (0 forward, 1 inverse).
//   output stream: tdata carries the substituted byte.
//   i_cfg_we / i_cfg_wdata write the low eight bits of the reduction polynomial
//   (bit 8 implied); write only while no request is in flight.
//   a request is taken when the unit is free; one shared euclid step unit then runs
//   one step per cycle until the remainder is zero, at most 16 steps for any byte.
//   the result is registered once the remainder is zero and the output register is
//   free; one request is in the unit at a time, and a new byte is taken only after
//   the unit has returned to idle.
//   the output register parts the two sides: a new request is taken while an
//   earlier result still waits; when the receiver stalls the finished unit holds
//   its result until the output register frees, and tready stays low meanwhile.
//   reset: polynomial returns to 0x1B, the unit goes idle, the output is emptied.
`default_nettype none

module gf256_sbox_forward_inverse
    import gfsbox_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] value
    input  logic       i_s_axis_tuser,   // [0] kind
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [7:0] result
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state     r_state;
    t_state     n_state;
    t_euclid    r_ev;
    t_euclid    n_ev;
    t_euclid    step_nxt;
    logic       r_kind;
    logic       n_kind;
    logic [7:0] r_poly;
    logic [7:0] n_poly;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [7:0] r_out_data;
    logic [7:0] n_out_data;

    logic       in_acc;
    logic       fin;
    logic [7:0] start_u;

    gfsbox_euclid_step u_step (
        .i_cur (r_ev),
        .o_nxt (step_nxt)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign fin    = (r_state == ST_RUN) && (r_ev.u == 9'd0)
                    && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        start_u     = (i_s_axis_tuser == KIND_INV)
                      ? affine8(i_s_axis_tdata, INV_ROW, INV_CONST) : i_s_axis_tdata;
        n_state     = r_state;
        n_ev        = r_ev;
        n_kind      = r_kind;
        n_poly      = i_cfg_we ? i_cfg_wdata : r_poly;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_RUN;
                    n_kind  = i_s_axis_tuser;
                    n_ev.u  = {1'b0, start_u};
                    n_ev.v  = {1'b1, r_poly};
                    n_ev.g0 = 8'd1;
                    n_ev.g1 = 8'd0;
                end
            end
            ST_RUN: begin
                if (r_ev.u != 9'd0) begin
                    n_ev = step_nxt;
                end else if (fin) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_data  = (r_kind == KIND_INV)
                                  ? r_ev.g1 : affine8(r_ev.g1, FWD_ROW, FWD_CONST);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ev       <= n_ev;
        r_kind     <= n_kind;
        r_out_data <= n_out_data;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_poly      <= POLY_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_poly      <= n_poly;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_RUN))
        else $error("unit not busy after request");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_ev.v != 9'd0))
        else $error("euclid divisor became zero");

    a_load_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_RUN))
        else $error("output loaded without a finished request");
`endif

endmodule

`default_nettype wire
